@@ design/slcl_pkg.sv @@
package slcl_pkg;

	// Field widths
	localparam int OFF_W  = 24;
	localparam int LINE_W = 13;
	localparam int COL_W  = 25;
	localparam int IDX_W  = 12;
	localparam int CNT_W  = 13;

	// Defaults for the top-level parameters
	localparam int MAX_LINES_DEF = 4096;

	// Stored line starts keep only this many low bits
	localparam int OFFSET_BITS = 24;
	localparam logic [OFF_W-1:0] OFF_MASK = (OFFSET_BITS >= OFF_W) ? {OFF_W{1'b1}} :
		OFF_W'((64'd1 << OFFSET_BITS) - 64'd1);

	// Stream word layout
	localparam int S_TDATA_W = 88;   // 12 + 24 + 24 + 24 = 84, padded to bytes
	localparam int M_TDATA_W = 128;  // 24 + 24 + 13 + 25 + 13 + 25 = 124, padded

	// Item kinds carried in s_tuser
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Location found by one search lane
	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0]  col;
		logic              fault;
	} lane_res_t;

endpackage

@@ design/slcl_tbl.sv @@
module slcl_tbl import slcl_pkg::*; #(
	parameter int DEPTH = MAX_LINES_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [OFF_W-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [OFF_W-1:0] rdata_a,
	output logic [OFF_W-1:0] rdata_b
);

	logic [OFF_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// one registered read port per lane
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

@@ design/slcl_lane.sv @@
module slcl_lane import slcl_pkg::*; #(
	parameter int MAX_LINES = MAX_LINES_DEF,
	parameter int AW        = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1,
	parameter int CW        = $clog2(MAX_LINES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [OFF_W-1:0] off,
	input  logic [CW-1:0]    n,
	input  logic             ack,
	output logic [AW-1:0]    raddr,
	input  logic [OFF_W-1:0] rdata,
	output logic             done,
	output lane_res_t        res
);

	typedef enum logic [4:0] {
		L_IDLE = 5'b00001,
		L_ADDR = 5'b00010,
		L_CMP  = 5'b00100,
		L_FIX  = 5'b01000,
		L_DONE = 5'b10000
	} lane_state_t;

	lane_state_t      state_q;
	logic [CW-1:0]    lo_q;
	logic [CW-1:0]    len_q;
	logic [OFF_W-1:0] off_q;
	lane_res_t        res_q;

	logic [CW-1:0] half;
	logic [CW-1:0] mid;
	logic [CW-1:0] k;

	assign half = len_q >> 1;
	assign mid  = lo_q + half;
	assign k    = (lo_q == '0) ? '0 : lo_q - CW'(1);

	// search probe while range is open, final line start once it closes
	assign raddr = (len_q == '0) ? k[AW-1:0] : mid[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						state_q <= (n == '0) ? L_DONE : L_ADDR;
					end
				end
				L_ADDR: begin
					state_q <= (len_q == '0) ? L_FIX : L_CMP;
				end
				L_CMP:  state_q <= L_ADDR;
				L_FIX:  state_q <= L_DONE;
				L_DONE: begin
					if (ack) begin
						state_q <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			L_IDLE: begin
				lo_q  <= '0;
				len_q <= n;
				off_q <= off;
				// empty table: line 1, column is offset + 1
				res_q.line  <= LINE_W'(1);
				res_q.col   <= COL_W'(off) + COL_W'(1);
				res_q.fault <= 1'b0;
			end
			L_CMP: begin
				if (rdata <= off_q) begin
					lo_q  <= mid + CW'(1);
					len_q <= len_q - half - CW'(1);
				end else begin
					len_q <= half;
				end
			end
			L_FIX: begin
				res_q.line <= LINE_W'(k) + LINE_W'(1);
				if (off_q < rdata) begin
					res_q.col   <= COL_W'(1);
					res_q.fault <= 1'b1;
				end else begin
					res_q.col   <= COL_W'(off_q) - COL_W'(rdata) + COL_W'(1);
					res_q.fault <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign done = (state_q == L_DONE);
	assign res  = res_q;

endmodule

@@ design/slcl_merge.sv @@
module slcl_merge import slcl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 capture,
	input  logic [OFF_W-1:0]     span_lo,
	input  logic [OFF_W-1:0]     span_hi,
	input  lane_res_t            res_s,
	input  lane_res_t            res_e,
	output logic                 free,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // clamped start, clamped end, start row,
	                                        // start column, end row, end column, pad
	output logic                 m_tuser    // order_fault
);

	logic                 valid_q;
	logic [M_TDATA_W-1:0] data_q;
	logic                 fault_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (capture) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			data_q <= {4'b0, res_e.col, res_e.line, res_s.col, res_s.line,
				span_hi, span_lo};
			fault_q <= res_s.fault | res_e.fault;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = fault_q;

endmodule

@@ design/span_line_column_locator_unit.sv @@
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid / s_tready  tdata: line_index, line_start_value, span_start,
//                                     span_end; tuser: op (0 load, 1 query)
// m_*       out  m_tvalid / m_tready  tdata: offsets, lines, columns; tuser: order_fault
// APB       in   psel/penable, pready 0x0 file_length, 0x4 line_count
//
// A load word writes at most one table entry; loads past the table depth are dropped.
// A query word runs two search lanes in parallel on the dual-read table; each
// probe is a registered read, then a compare, and a lane makes at most
// ceil(log2(n+1)) probes for n lines in use, then reads the final line start
// and fixes up the column; with no lines in use it goes straight to done. The
// input is held until both lanes are done and the result is captured.
// The next word is taken once the result sits in the output register, even if
// m_tready is low; a later query waits in its done state until that register frees.
// No clearing pass after reset; the table is undefined until written.
module span_line_column_locator_unit import slcl_pkg::*; #(
	parameter int MAX_LINES = MAX_LINES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // line_index, line_start_value, span_start,
	                                        // span_end, pad
	input  logic                 s_tuser,   // op
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // clamped start, clamped end, start row,
	                                        // start column, end row, end column, pad
	output logic                 m_tuser,   // order_fault
	// register port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int CW = $clog2(MAX_LINES + 1);

	localparam logic REG_FILE_LENGTH = 1'b0;
	localparam logic REG_LINE_COUNT  = 1'b1;

	typedef enum logic [1:0] {
		T_IDLE = 2'b01,
		T_RUN  = 2'b10
	} top_state_t;

	top_state_t       state_q;
	logic [OFF_W-1:0] file_length_q;
	logic [CNT_W-1:0] line_count_q;
	logic [OFF_W-1:0] off_s_q;
	logic [OFF_W-1:0] off_e_q;

	// input word fields
	logic [IDX_W-1:0] line_index;
	logic [OFF_W-1:0] line_start_value;
	logic [OFF_W-1:0] span_start;
	logic [OFF_W-1:0] span_end;

	assign line_index       = s_tdata[11:0];
	assign line_start_value = s_tdata[35:12];
	assign span_start       = s_tdata[59:36];
	assign span_end         = s_tdata[83:60];

	logic             s_acc;
	logic             tbl_we;
	logic             lane_start;
	logic             lane_ack;
	logic [OFF_W-1:0] clamp_s;
	logic [OFF_W-1:0] clamp_e0;
	logic [OFF_W-1:0] clamp_e;
	logic [CW-1:0]    n_lines;

	logic [AW-1:0]    raddr_a;
	logic [AW-1:0]    raddr_b;
	logic [OFF_W-1:0] rdata_a;
	logic [OFF_W-1:0] rdata_b;
	logic             done_a;
	logic             done_b;
	lane_res_t        res_a;
	lane_res_t        res_b;
	logic             out_free;

	assign s_tready = (state_q == T_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// out-of-range loads are dropped
	assign tbl_we     = s_acc && (s_tuser == OP_LOAD) && (32'(line_index) < MAX_LINES);
	assign lane_start = s_acc && (s_tuser == OP_QUERY);

	// clamp: s to length, e to [s, length]
	assign clamp_s  = (span_start > file_length_q) ? file_length_q : span_start;
	assign clamp_e0 = (span_end < clamp_s) ? clamp_s : span_end;
	assign clamp_e  = (clamp_e0 > file_length_q) ? file_length_q : clamp_e0;

	// line_count beyond table depth saturates
	assign n_lines = (32'(line_count_q) > MAX_LINES) ? CW'(MAX_LINES) : CW'(line_count_q);

	assign lane_ack = (state_q == T_RUN) && done_a && done_b && out_free;

	// ---------------- register port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
			line_count_q  <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_FILE_LENGTH: file_length_q <= pwdata[OFF_W-1:0];
				REG_LINE_COUNT:  line_count_q  <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FILE_LENGTH: prdata = 32'(file_length_q);
			REG_LINE_COUNT:  prdata = 32'(line_count_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (lane_start) begin
						state_q <= T_RUN;
					end
				end
				T_RUN: begin
					if (lane_ack) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (lane_start) begin
			off_s_q <= clamp_s;
			off_e_q <= clamp_e;
		end
	end

	// ---------------- datapath ----------------
	slcl_tbl #(
		.DEPTH (MAX_LINES),
		.AW    (AW)
	) u_tbl (
		.clk     (clk),
		.we      (tbl_we),
		.waddr   (AW'(line_index)),
		.wdata   (line_start_value & OFF_MASK),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// lane a locates the span start, lane b the span end
	slcl_lane #(
		.MAX_LINES (MAX_LINES),
		.AW        (AW),
		.CW        (CW)
	) u_lane_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.off    (clamp_s),
		.n      (n_lines),
		.ack    (lane_ack),
		.raddr  (raddr_a),
		.rdata  (rdata_a),
		.done   (done_a),
		.res    (res_a)
	);

	slcl_lane #(
		.MAX_LINES (MAX_LINES),
		.AW        (AW),
		.CW        (CW)
	) u_lane_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.off    (clamp_e),
		.n      (n_lines),
		.ack    (lane_ack),
		.raddr  (raddr_b),
		.rdata  (rdata_b),
		.done   (done_b),
		.res    (res_b)
	);

	slcl_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.capture  (lane_ack),
		.span_lo  (off_s_q),
		.span_hi  (off_e_q),
		.res_s    (res_a),
		.res_e    (res_b),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// ---------------- checks ----------------
	a_lane_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(done_a || done_b) |-> (state_q == T_RUN))
		else $error("search lane done outside a query");

	a_span_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_RUN) |-> (off_s_q <= off_e_q) && (off_e_q <= file_length_q))
		else $error("clamped span out of order");

	a_capture_shows: assert property (@(posedge clk) disable iff (!arst_n)
		lane_ack |=> m_tvalid)
		else $error("merged result not presented");

	a_no_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_RUN) |-> !tbl_we)
		else $error("table written during a search");

endmodule

@@ bench/slcl_ledger_pkg.sv @@
`timescale 1ns / 100ps

package slcl_ledger_pkg;
	import slcl_pkg::*;

	// register byte addresses
	localparam logic [2:0] REG_FILE_LENGTH = 3'h0;
	localparam logic [2:0] REG_LINE_COUNT  = 3'h4;

	typedef struct packed {
		logic [OFF_W-1:0]  clamped_start;
		logic [OFF_W-1:0]  clamped_end;
		logic [LINE_W-1:0] start_row;
		logic [COL_W-1:0]  start_column;
		logic [LINE_W-1:0] end_row;
		logic [COL_W-1:0]  end_column;
		logic              order_fault;
	} span_location_t;

	// Holds a copy of the line start table and the registers, works out the
	// location of each accepted query and checks results in order.
	class line_column_ledger;
		logic [OFF_W-1:0] start_table [MAX_LINES_DEF];
		logic [OFF_W-1:0] text_length;
		logic [CNT_W-1:0] lines_in_use;
		span_location_t   due_locations [$];
		int unsigned      mismatches;
		int unsigned      results_seen;

		function new();
			text_length  = '0;
			lines_in_use = '0;
			mismatches   = 0;
			results_seen = 0;
			foreach (start_table[i]) start_table[i] = '0;
		endfunction

		function void write_reg(logic [2:0] addr, logic [31:0] value);
			if (addr == REG_FILE_LENGTH) text_length = value[OFF_W-1:0];
			else if (addr == REG_LINE_COUNT) lines_in_use = value[CNT_W-1:0];
		endfunction

		function int unsigned pending();
			return due_locations.size();
		endfunction

		// upper-bound search for the last start not above off
		function void locate_offset(input logic [OFF_W-1:0] off,
				output logic [LINE_W-1:0] line, output logic [COL_W-1:0] col,
				inout logic fault);
			int unsigned used, lo, len, half, mid, k;
			used = (lines_in_use > MAX_LINES_DEF) ? MAX_LINES_DEF : lines_in_use;
			if (used == 0) begin
				line = LINE_W'(1);
				col  = COL_W'(off) + 1'b1;
				return;
			end
			lo  = 0;
			len = used;
			while (len > 0) begin
				half = len >> 1;
				mid  = lo + half;
				if (start_table[mid] <= off) begin
					lo  = mid + 1;
					len = len - half - 1;
				end else begin
					len = half;
				end
			end
			k    = (lo > 0) ? lo - 1 : 0;
			line = LINE_W'(k + 1);
			if (off < start_table[k]) begin
				col   = COL_W'(1);
				fault = 1'b1;
			end else begin
				col = COL_W'(off - start_table[k]) + 1'b1;
			end
		endfunction

		function void note_word(logic op, logic [IDX_W-1:0] idx,
				logic [OFF_W-1:0] start_value, logic [OFF_W-1:0] span_start,
				logic [OFF_W-1:0] span_end);
			span_location_t   loc;
			logic [OFF_W-1:0] s, e;
			if (op == OP_LOAD) begin
				if (idx < MAX_LINES_DEF) start_table[idx] = start_value & OFF_MASK;
				return;
			end
			s = (span_start > text_length) ? text_length : span_start;
			e = (span_end < s) ? s : span_end;
			if (e > text_length) e = text_length;
			loc.clamped_start = s;
			loc.clamped_end   = e;
			loc.order_fault   = 1'b0;
			locate_offset(s, loc.start_row, loc.start_column, loc.order_fault);
			locate_offset(e, loc.end_row, loc.end_column, loc.order_fault);
			due_locations.push_back(loc);
		endfunction

		function void report_mismatch(string msg);
			mismatches++;
			$display("mismatch: %s", msg);
		endfunction

		function void compare_field(string field, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
					results_seen, field, got, want));
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] word, logic fault);
			span_location_t got, want;
			results_seen++;
			got.clamped_start = word[0 +: OFF_W];
			got.clamped_end   = word[OFF_W +: OFF_W];
			got.start_row     = word[2*OFF_W +: LINE_W];
			got.start_column  = word[2*OFF_W+LINE_W +: COL_W];
			got.end_row       = word[2*OFF_W+LINE_W+COL_W +: LINE_W];
			got.end_column    = word[2*OFF_W+2*LINE_W+COL_W +: COL_W];
			got.order_fault   = fault;
			if (due_locations.size() == 0) begin
				report_mismatch($sformatf("result %0d with no query pending", results_seen));
				return;
			end
			want = due_locations.pop_front();
			compare_field("clamped start", got.clamped_start, want.clamped_start);
			compare_field("clamped end", got.clamped_end, want.clamped_end);
			compare_field("start row", got.start_row, want.start_row);
			compare_field("start column", got.start_column, want.start_column);
			compare_field("end row", got.end_row, want.end_row);
			compare_field("end column", got.end_column, want.end_column);
			compare_field("order fault", got.order_fault, want.order_fault);
		endfunction
	endclass

endpackage

@@ bench/span_line_column_locator_unit_test.sv @@
`timescale 1ns / 100ps

module span_line_column_locator_unit_test;
	import slcl_pkg::*;
	import slcl_ledger_pkg::*;

	// loads carry no result, so this settle time is let pass after the last result
	// before touching registers
	localparam int SETTLE_CYCLES = 40;
	// long receiver hold-off that fills the block and stalls its input
	localparam int HOLD_CYCLES   = 300;
	// cycles with no word moving on either side before we give up
	localparam int QUIET_LIMIT   = 5000;
	localparam int IDLE_PCT      = 76;
	localparam int MIXED_PCT     = 13;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // line_index, line_start_value, span_start,
	                                      // span_end, pad
	logic                 s_tuser  = 1'b0; // op
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // clamped start, clamped end, start row,
	                                      // start column, end row, end column, pad
	logic                 m_tuser;        // order_fault
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [2:0]           paddr    = '0;
	logic [31:0]          pwdata   = '0;
	logic [31:0]          prdata;
	logic                 pready;

	line_column_ledger ledger;

	int unsigned      src_idle_pct  = 0;
	int unsigned      snk_stall_pct = 0;
	int unsigned      holds_asked   = 0;  // bumped by the stimulus, served by the sink
	int unsigned      quiet_cycles  = 0;
	logic [OFF_W-1:0] cur_length    = '0;
	int unsigned      cur_lines     = 0;  // line_count after clamping to the table size

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	span_line_column_locator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : result_sink
		int unsigned holds_done;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				holds_done = holds_asked;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Every word that leaves the block is checked against the oldest location due.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) ledger.check_result(m_tdata, m_tuser);
	end

	// Watchdog: a hung handshake ends the run.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Setup then access phase; psel stays up so two writes can follow back to back.
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		ledger.write_reg(addr, value);
	endtask

	// Input side: random idle cycles ahead of each word. Valid is only
	// lowered when a gap is taken, so back-to-back words keep it high.
	task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
			input logic [OFF_W-1:0] start_value, input logic [OFF_W-1:0] span_start,
			input logic [OFF_W-1:0] span_end);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= S_TDATA_W'({span_end, span_start, start_value, idx});
		do @(posedge clk); while (!s_tready);
		ledger.note_word(op, idx, start_value, span_start, span_end);
	endtask

	// unused fields get random bits so every field bit of the input word toggles
	task automatic send_load(input logic [IDX_W-1:0] idx, input logic [OFF_W-1:0] value);
		send_word(OP_LOAD, idx, value, OFF_W'($urandom), OFF_W'($urandom));
	endtask

	task automatic send_query(input logic [OFF_W-1:0] span_start,
			input logic [OFF_W-1:0] span_end);
		send_word(OP_QUERY, IDX_W'($urandom), OFF_W'($urandom), span_start, span_end);
	endtask

	// Stop offering, wait for every pending location, then let in-flight loads finish.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [OFF_W-1:0] length, input logic [CNT_W-1:0] lines);
		drain();
		apb_write(REG_FILE_LENGTH, 32'(length));
		apb_write(REG_LINE_COUNT, 32'(lines));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_length = length;
		cur_lines  = (lines > MAX_LINES_DEF) ? MAX_LINES_DEF : lines;
	endtask

	// Writes every entry in use with ascending starts, so no query reads an
	// unwritten entry. Sometimes the first line starts past 0, giving offsets
	// before the first start. Zero steps make empty lines; starts may pass
	// the text length and saturate at the top offset.
	task automatic load_ascending_starts();
		int unsigned step, next;
		step = 2 * (int'(cur_length) / ((cur_lines == 0) ? 1 : cur_lines)) + 1;
		next = ($urandom_range(4) == 0) ? $urandom_range(step) + 1 : 0;
		for (int i = 0; i < cur_lines; i++) begin
			send_load(IDX_W'(i), (next > 32'hFFFFFF) ? '1 : OFF_W'(next));
			next = next + $urandom_range(step);
		end
	endtask

	// Offsets biased toward the edges: zero, the length, the top code, and
	// right around a line start.
	function automatic logic [OFF_W-1:0] pick_offset();
		logic [OFF_W-1:0] near;
		near = (cur_lines > 0) ? ledger.start_table[$urandom_range(cur_lines - 1)] : '0;
		case ($urandom_range(9)) inside
			0: return '0;
			1: return cur_length;
			2: return '1;
			3: return OFF_W'($urandom);
			[4:5]: return near + OFF_W'($urandom_range(2)) - OFF_W'(1);
			default: return OFF_W'($urandom_range(cur_length));
		endcase
	endfunction

	// One setting of the registers: a fresh table if refill is set, then a mix of queries,
	// order-keeping rewrites and stray loads.
	task automatic run_phase(input logic [OFF_W-1:0] length, input logic [CNT_W-1:0] lines,
			input int unsigned words, input int unsigned src_pct,
			input int unsigned snk_pct, input bit refill, input bit with_hold);
		int unsigned      roll, at;
		logic [OFF_W-1:0] first, lower, upper;
		configure(length, lines);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		if (refill) load_ascending_starts();
		for (int i = 0; i < words; i++) begin
			if (with_hold && i == 20) holds_asked++;
			roll = $urandom_range(99);
			if (roll < 72) begin
				first = pick_offset();
				// short spans mostly; independent ends also give end below start
				send_query(first, ($urandom_range(3) == 0) ? pick_offset() :
					first + OFF_W'($urandom_range(64)));
			end else if (roll < 90 && cur_lines > 0) begin
				// new start between its neighbors keeps the table ascending
				at    = $urandom_range(cur_lines - 1);
				lower = (at > 0) ? ledger.start_table[at - 1] : '0;
				upper = (at + 1 < cur_lines) ? ledger.start_table[at + 1] :
					ledger.start_table[at];
				send_load(IDX_W'(at), OFF_W'($urandom_range(upper, lower)));
			end else begin
				// stray load anywhere; inside the lines in use it breaks the order
				send_load(IDX_W'($urandom), OFF_W'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		ledger = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty table and zero length: everything clamps to offset 0
		configure('0, '0);
		send_query('0, '0);
		send_query('1, '1);
		// empty table, full length: column is offset + 1, up to 2^24
		configure('1, '0);
		send_query('0, '1);
		send_query('1, '0);
		send_query(OFF_W'(5), OFF_W'(3));
		// three short lines
		configure(OFF_W'(1000), CNT_W'(3));
		send_load(IDX_W'(0), OFF_W'(10));
		send_load(IDX_W'(1), OFF_W'(100));
		send_load(IDX_W'(2), OFF_W'(500));
		send_query(OFF_W'(0), OFF_W'(5));       // before the first start
		send_query(OFF_W'(10), OFF_W'(10));     // single offset
		send_query(OFF_W'(99), OFF_W'(100));    // across a line boundary
		send_query(OFF_W'(600), OFF_W'(2000));  // end clamps to length
		send_query('1, '1);                     // both clamp to length
		send_load('1, '1);                      // top entry, outside the lines in use
		send_load(IDX_W'(1), OFF_W'(5));        // table no longer ascending
		send_query(OFF_W'(50), OFF_W'(60));

		// line count past the table size searches all entries; with zero length
		// every offset is 0, so the search walks down through the power-of-two
		// entries to entry 0, which are the only ones read
		configure('0, '1);
		send_load(IDX_W'(0), OFF_W'(1));
		for (int i = 0; i < IDX_W; i++) send_load(IDX_W'(1 << i), OFF_W'(1));
		send_query('0, '0);
		send_query('1, '1);
		send_query(OFF_W'(7), OFF_W'(3));

		// random part, several idle mixes
		run_phase(OFF_W'(200), CNT_W'(1), 150, 0, 0, 1'b1, 1'b0);
		run_phase('1, CNT_W'(2), 150, IDLE_PCT, 0, 1'b1, 1'b0);
		run_phase(OFF_W'(5000), CNT_W'(7), 150, 0, IDLE_PCT, 1'b1, 1'b0);
		run_phase('0, CNT_W'(4), 100, MIXED_PCT, MIXED_PCT, 1'b1, 1'b0);
		run_phase(OFF_W'(60000), CNT_W'(33), 150, 0, 0, 1'b1, 1'b1);
		run_phase(OFF_W'(1 << 20), CNT_W'(150), 150, IDLE_PCT, 0, 1'b1, 1'b0);
		run_phase(OFF_W'(300), CNT_W'(0), 125, 0, IDLE_PCT, 1'b0, 1'b0);
		run_phase(OFF_W'(800), CNT_W'(12), 150, MIXED_PCT, MIXED_PCT, 1'b1, 1'b0);
		run_phase(OFF_W'(24'hFFFFFE), CNT_W'(120), 150, 0, IDLE_PCT, 1'b1, 1'b0);
		run_phase(OFF_W'(100000), CNT_W'(64), 150, IDLE_PCT, 0, 1'b1, 1'b0);

		drain();
		if (ledger.mismatches == 0 && ledger.pending() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule

@@ files.f @@
design/slcl_pkg.sv
design/slcl_tbl.sv
design/slcl_lane.sv
design/slcl_merge.sv
design/span_line_column_locator_unit.sv
bench/slcl_ledger_pkg.sv
bench/span_line_column_locator_unit_test.sv
